// ===== design/datetime_string_parser_assert.svh =====
// assertion macros for the datetime string parser
// expects clk and rst_n in the including module
`ifndef DATETIME_STRING_PARSER_ASSERT_SVH
`define DATETIME_STRING_PARSER_ASSERT_SVH

// same-cycle implication
`define DTSP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtsp assertion failed");

// next-cycle implication
`define DTSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtsp assertion failed");

`endif

// ===== design/dtsp_pkg.sv =====
// types, constants and helpers for the datetime string parser
// no dependencies
package dtsp_pkg;

  localparam logic [4:0] STR_LEN    = 5'd19;
  localparam logic [4:0] POS_SAT    = 5'd20;
  localparam logic [4:0] POS_DASH1  = 5'd4;
  localparam logic [4:0] POS_DASH2  = 5'd7;
  localparam logic [4:0] POS_SPACE  = 5'd10;
  localparam logic [4:0] POS_COLON1 = 5'd13;
  localparam logic [4:0] POS_COLON2 = 5'd16;
  localparam logic [4:0] POS_YEAR_END   = 5'd3;
  localparam logic [4:0] POS_MONTH_END  = 5'd6;
  localparam logic [4:0] POS_DAY_END    = 5'd9;
  localparam logic [4:0] POS_HOUR_END   = 5'd12;
  localparam logic [4:0] POS_MINUTE_END = 5'd15;

  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [6:0] MAX_MONTH  = 7'd12;
  localparam logic [6:0] MAX_HOUR   = 7'd23;
  localparam logic [6:0] MAX_MINSEC = 7'd59;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FORMAT = 3'd1,
    ST_DIGIT  = 3'd2,
    ST_DATE   = 3'd3,
    ST_TIME   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } in_req_t;

  typedef struct packed {
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [16:0] seconds_of_day;
    status_t     status;
  } out_req_t;

  // accumulated fields including the current character
  typedef struct packed {
    logic        len_ok;
    logic        format_bad;
    logic        digit_bad;
    logic        leap;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } scan_t;

  function automatic logic [4:0] month_len(input logic [6:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11: len = 5'd30;
      7'd2: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== design/dtsp_scan.sv =====
// position counter, separator checks and digit accumulators
// depends on dtsp_pkg
module dtsp_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  dtsp_pkg::in_req_t req,
  output dtsp_pkg::scan_t  scan
);
  import dtsp_pkg::*;

  logic [4:0]  pos_r, pos_nxt;
  logic        format_bad_r, format_bad_nxt;
  logic        digit_bad_r, digit_bad_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  month_r, month_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  minute_r, minute_nxt;
  logic [6:0]  second_r, second_nxt;
  // hundreds value mod 4 and "last two digits zero"
  logic [1:0]  cent_r, cent_nxt;
  logic        lo_zero_r, lo_zero_nxt;
  logic        is_dig;
  logic [3:0]  dig;
  logic        leap;

  function automatic logic [6:0] fold7(input logic [6:0] acc, input logic [3:0] d);
    return 7'(acc * 7'd10 + 7'(d));
  endfunction

  always_comb begin
    is_dig         = (req.char_code >= CH_ZERO) && (req.char_code <= CH_NINE);
    dig            = is_dig ? req.char_code[3:0] : 4'd0;
    format_bad_nxt = format_bad_r;
    digit_bad_nxt  = digit_bad_r;
    year_nxt       = year_r;
    month_nxt      = month_r;
    day_nxt        = day_r;
    hour_nxt       = hour_r;
    minute_nxt     = minute_r;
    second_nxt     = second_r;
    cent_nxt       = cent_r;
    lo_zero_nxt    = lo_zero_r;
    if (pos_r >= STR_LEN) begin
      format_bad_nxt = 1'b1;
    end else if (pos_r == POS_DASH1 || pos_r == POS_DASH2) begin
      if (req.char_code != CH_DASH) format_bad_nxt = 1'b1;
    end else if (pos_r == POS_SPACE) begin
      if (req.char_code != CH_SPACE) format_bad_nxt = 1'b1;
    end else if (pos_r == POS_COLON1 || pos_r == POS_COLON2) begin
      if (req.char_code != CH_COLON) format_bad_nxt = 1'b1;
    end else if (!is_dig) begin
      digit_bad_nxt = 1'b1;
    end else if (pos_r <= POS_YEAR_END) begin
      year_nxt = 14'(year_r * 14'd10 + 14'(dig));
      case (pos_r[1:0])
        2'd0:    cent_nxt = {dig[0], 1'b0};
        2'd1:    cent_nxt = 2'(cent_r + dig[1:0]);
        2'd2:    lo_zero_nxt = (dig == 4'd0);
        default: lo_zero_nxt = lo_zero_r && (dig == 4'd0);
      endcase
    end else if (pos_r <= POS_MONTH_END) begin
      month_nxt = fold7(month_r, dig);
    end else if (pos_r <= POS_DAY_END) begin
      day_nxt = fold7(day_r, dig);
    end else if (pos_r <= POS_HOUR_END) begin
      hour_nxt = fold7(hour_r, dig);
    end else if (pos_r <= POS_MINUTE_END) begin
      minute_nxt = fold7(minute_r, dig);
    end else begin
      second_nxt = fold7(second_r, dig);
    end
    pos_nxt = (pos_r < POS_SAT) ? 5'(pos_r + 5'd1) : pos_r;
    leap    = (year_nxt[1:0] == 2'd0 && !lo_zero_nxt) || (lo_zero_nxt && cent_nxt == 2'd0);

    scan.len_ok     = (pos_r == 5'(STR_LEN - 5'd1));
    scan.format_bad = format_bad_nxt;
    scan.digit_bad  = digit_bad_nxt;
    scan.leap       = leap;
    scan.year       = year_nxt;
    scan.month      = month_nxt;
    scan.day        = day_nxt;
    scan.hour       = hour_nxt;
    scan.minute     = minute_nxt;
    scan.second     = second_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && req.end_of_string)) begin
      pos_r        <= '0;
      format_bad_r <= 1'b0;
      digit_bad_r  <= 1'b0;
      year_r       <= '0;
      month_r      <= '0;
      day_r        <= '0;
      hour_r       <= '0;
      minute_r     <= '0;
      second_r     <= '0;
      cent_r       <= '0;
      lo_zero_r    <= 1'b0;
    end else if (step) begin
      pos_r        <= pos_nxt;
      format_bad_r <= format_bad_nxt;
      digit_bad_r  <= digit_bad_nxt;
      year_r       <= year_nxt;
      month_r      <= month_nxt;
      day_r        <= day_nxt;
      hour_r       <= hour_nxt;
      minute_r     <= minute_nxt;
      second_r     <= second_nxt;
      cent_r       <= cent_nxt;
      lo_zero_r    <= lo_zero_nxt;
    end
  end

endmodule

// ===== design/dtsp_check.sv =====
// final validation, status priority and seconds of day
// depends on dtsp_pkg
module dtsp_check (
  input  dtsp_pkg::scan_t   scan,
  output dtsp_pkg::out_req_t res
);
  import dtsp_pkg::*;

  status_t     st;
  logic        date_bad;
  logic        time_bad;
  logic [16:0] sod;

  always_comb begin
    date_bad = (scan.month == 7'd0) || (scan.month > MAX_MONTH) || (scan.day == 7'd0) ||
               (scan.day > {2'b00, month_len(scan.month, scan.leap)});
    time_bad = (scan.hour > MAX_HOUR) || (scan.minute > MAX_MINSEC) ||
               (scan.second > MAX_MINSEC);
    if (scan.format_bad || !scan.len_ok) st = ST_FORMAT;
    else if (scan.digit_bad) st = ST_DIGIT;
    else if (date_bad) st = ST_DATE;
    else if (time_bad) st = ST_TIME;
    else st = ST_OK;

    sod = 17'({12'd0, scan.hour[4:0]} * 17'd3600) +
          17'({11'd0, scan.minute[5:0]} * 17'd60) + {11'd0, scan.second[5:0]};

    res = '0;
    res.status = st;
    if (st == ST_OK) begin
      res.year_out       = scan.year;
      res.month_out      = scan.month[3:0];
      res.day_out        = scan.day[4:0];
      res.hour_out       = scan.hour[4:0];
      res.minute_out     = scan.minute[5:0];
      res.second_out     = scan.second[5:0];
      res.seconds_of_day = sod;
    end
  end

endmodule

// ===== design/datetime_string_parser.sv =====
// top level of the datetime string parser: input register, scan, check, result register
// depends on dtsp_pkg, dtsp_scan, dtsp_check and datetime_string_parser_assert.svh
//
// channel  dir  payload    request
// in_      in   in_req_t   one character, end_of_string on the last
// out_     out  out_req_t  one parsed result per string
//
// one character per cycle sustained unless a last character waits on a stalled result;
// a result goes from the input register through scan and check into the result register
// rst_n is synchronous and clears the position, flags and accumulators
// a stalled result blocks only the next last character; other characters keep flowing
module datetime_string_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtsp_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dtsp_pkg::out_req_t  out_data
);
  import dtsp_pkg::*;

  logic     in_valid_r, in_valid_nxt;
  in_req_t  in_data_r;
  logic     out_valid_r, out_valid_nxt;
  out_req_t out_data_r;
  logic     out_free;
  logic     step;
  logic     emit;
  scan_t    scan;
  out_req_t res;

  dtsp_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .req   (in_data_r),
    .scan  (scan)
  );

  dtsp_check u_check (
    .scan (scan),
    .res  (res)
  );

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    step          = in_valid_r && (!in_data_r.end_of_string || out_free);
    emit          = step && in_data_r.end_of_string;
    in_stall      = in_valid_r && !step;
    in_valid_nxt  = in_stall ? 1'b1 : in_valid;
    out_valid_nxt = emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data_r <= in_data;
    end
    if (emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "datetime_string_parser_assert.svh"

  `DTSP_ASSERT_IMPL(a_err_zero, out_valid_r && out_data_r.status != ST_OK,
    out_data_r.year_out == 14'd0 && out_data_r.seconds_of_day == 17'd0)
  `DTSP_ASSERT_IMPL(a_ok_month, out_valid_r && out_data_r.status == ST_OK,
    out_data_r.month_out != 4'd0 && out_data_r.day_out != 5'd0)
  `DTSP_ASSERT_IMPL(a_stall_cause, in_stall,
    in_valid_r && in_data_r.end_of_string && out_valid_r)
  `DTSP_ASSERT_NEXT(a_emit_valid, emit, out_valid_r)

endmodule
